[hw/rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Types, constants and register map shared by the bicubic scanline scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  localparam int BSS_MAX_WIDTH = 2048;
  localparam int BSS_LINE_ROWS = 8;
  localparam int CFG_AW        = 5;

  localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COMPONENTS = 3'd4;
  localparam logic [2:0] REG_STEP_X     = 3'd5;
  localparam logic [2:0] REG_STEP_Y     = 3'd6;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic [11:0] in_width;
    logic [11:0] in_height;
    logic [11:0] out_width;
    logic [11:0] out_height;
    logic [2:0]  components;
    logic [27:0] step_x;
    logic [27:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_comp0;
    logic [7:0] in_comp1;
    logic [7:0] in_comp2;
    logic [7:0] in_comp3;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       pixel_valid;
    logic [7:0] out_comp0;
    logic [7:0] out_comp1;
    logic [7:0] out_comp2;
    logic [7:0] out_comp3;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic [3:0][11:0] tap;
    logic [15:0]      frac;
  } taps_t;

  typedef struct packed {
    logic take_in;
    logic push;
    logic mul_y;
    logic mul_x;
    logic lat_y;
    logic lat_x;
    logic lat_slot;
    logic res_clear;
    logic rd_run;
    logic run_h;
    logic run_v;
    logic advance;
    logic upd_oldest;
    logic out_load;
  } bss_cmd_t;

  typedef struct packed {
    logic pull_ok;
    logic rd_done;
    logic h_done;
    logic v_done;
    logic col_last;
    logic row_more;
    logic out_free;
  } bss_sts_t;

endpackage

`default_nettype wire

[hw/rtl/bss_cubic.sv]
// ----------------------------------------------------------------------------
// bss_cubic
// Four-lane Catmull-Rom cubic, five pipeline stages, exact floor and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bss_cubic import bss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 feed,
  input  wire logic [1:0]           feed_tag,
  input  wire logic [3:0][3:0][7:0] taps,
  input  wire logic [15:0]          frac,
  output logic                      result_valid,
  output logic [1:0]                result_tag,
  output logic [3:0][7:0]           result
);

  logic [4:0]             vld;
  logic [3:0][1:0]        tg;
  logic [2:0][15:0]       tp;
  logic signed [9:0]      b1 [4];
  logic signed [11:0]     c1 [4];
  logic signed [11:0]     d1 [4];
  logic signed [9:0]      b2 [4];
  logic signed [29:0]     u1 [4];
  logic signed [47:0]     u2 [4];
  logic signed [63:0]     tot [4];
  logic [3:0][7:0]        p1s;
  logic [2:0][3:0][7:0]   p1p;
  logic signed [16:0]     ts0, ts1, ts2;

  assign ts0 = $signed({1'b0, tp[0]});
  assign ts1 = $signed({1'b0, tp[1]});
  assign ts2 = $signed({1'b0, tp[2]});

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p1s[l] = taps[1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], feed};
    end
  end

  always_ff @(posedge clk) begin
    tg <= {tg[2:0], feed_tag};
    result_tag <= tg[3];
    tp <= {tp[1:0], frac};
    p1p <= {p1p[1:0], p1s};
    for (int l = 0; l < 4; l++) begin
      b1[l] <= 10'($signed({2'b0, taps[2][l]}) - $signed({2'b0, taps[0][l]}));
      c1[l] <= 12'(2 * $signed({4'b0, taps[0][l]}) - 5 * $signed({4'b0, taps[1][l]})
                   + 4 * $signed({4'b0, taps[2][l]}) - $signed({4'b0, taps[3][l]}));
      d1[l] <= 12'(3 * ($signed({4'b0, taps[1][l]}) - $signed({4'b0, taps[2][l]}))
                   + $signed({4'b0, taps[3][l]}) - $signed({4'b0, taps[0][l]}));
      b2[l]  <= b1[l];
      u1[l]  <= (30'(c1[l]) <<< 16) + 30'(ts0) * 30'(d1[l]);
      u2[l]  <= (48'(b2[l]) <<< 32) + 48'(ts1) * 48'(u1[l]);
      tot[l] <= (64'($signed({1'b0, p1p[2][l]})) <<< 49) + 64'(ts2) * 64'(u2[l]);
      if (tot[l][63]) begin
        result[l] <= 8'd0;
      end else if (|tot[l][62:57]) begin
        result[l] <= 8'd255;
      end else begin
        result[l] <= tot[l][56:49];
      end
    end
  end

  assign result_valid = vld[4];

endmodule

`default_nettype wire

[hw/rtl/bss_dp.sv]
// ----------------------------------------------------------------------------
// bss_dp
// Datapath: line ring memory, counters, tap position unit, cubic feed and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bss_dp import bss_pkg::*; #(
  parameter int MAX_WIDTH = BSS_MAX_WIDTH,
  parameter int LINE_ROWS = BSS_LINE_ROWS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire bss_cmd_t cmd,
  output bss_sts_t      sts,
  input  wire in_word_t in_data,
  output out_word_t     out_data,
  output logic          out_valid,
  input  wire logic     out_stall
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(LINE_ROWS);
  localparam int DEPTH = MAX_WIDTH * LINE_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RECIP = 65536 / LINE_ROWS;

  function automatic logic [11:0] eff_width(input logic [11:0] v);
    logic [11:0] r;
    if (v == 12'd0) begin
      r = 12'd1;
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      r = 12'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] row_slot(input logic [11:0] v);
    logic [28:0] prod;
    logic [11:0] q;
    logic [11:0] r;
    prod = 29'(v) * 29'(RECIP);
    q = prod[27:16];
    r = v - 12'(q * 12'(LINE_ROWS));
    if (r >= 12'(LINE_ROWS)) begin
      r = r - 12'(LINE_ROWS);
    end
    return SW'(r);
  endfunction

  logic [11:0] iw, ih, ow, oh;
  logic [2:0]  nc;
  logic        pass;

  in_word_t    in_r;
  logic [11:0] rows_rcv;
  logic [CW-1:0] wcol;
  logic [SW-1:0] wslot;
  logic [11:0] oldest;
  logic [11:0] out_row;
  logic [CW-1:0] out_col;
  logic        push_ok;

  logic [40:0] prod_r;
  logic [11:0] i_r;
  logic        sel_x;
  logic [11:0] size, lastidx, ta, tb, pa;
  logic [40:0] pos_raw, pos_top, posc;
  taps_t       tu;
  taps_t       ty_r, tx_r;
  logic [3:0][SW-1:0] ysl;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic [AW-1:0] waddr, raddr;
  logic        we;
  logic [4:0]  rd_cnt;
  logic        rd_issue;
  logic        cap_en;
  logic [3:0]  cap_idx;
  logic [3:0][3:0][31:0] tpx;

  logic [2:0]  iss_cnt;
  logic        feed;
  logic [3:0][3:0][7:0] cub_taps;
  logic [15:0] cub_frac;
  logic        cub_valid;
  logic [1:0]  cub_tag;
  logic [3:0][7:0] cub_res;
  logic [3:0][3:0][7:0] h;
  logic [3:0][7:0] pix;
  logic        h_done, v_done;
  logic        col_last, row_more;
  out_word_t   res;

  assign iw = eff_width(cfg.in_width);
  assign ow = eff_width(cfg.out_width);
  assign ih = (cfg.in_height == 12'd0) ? 12'd1 : cfg.in_height;
  assign oh = (cfg.out_height == 12'd0) ? 12'd1 : cfg.out_height;
  assign nc = (cfg.components == 3'd0) ? 3'd1 :
              (cfg.components > 3'd4) ? 3'd4 : cfg.components;
  assign pass = (iw == ow) && (ih == oh);

  assign push_ok = (rows_rcv < ih) && (13'(rows_rcv) < 13'(oldest) + 13'(LINE_ROWS));

  // tap position unit
  assign size    = sel_x ? iw : ih;
  assign lastidx = size - 12'd1;
  assign pos_raw = (prod_r <= 41'd65536) ? '0 : ((prod_r - 41'd65536) >> 1);
  assign pos_top = 41'({lastidx, 16'd0});
  assign posc    = (pos_raw > pos_top) ? pos_top : pos_raw;
  assign ta      = posc[27:16];
  assign tb      = (ta < lastidx) ? ta + 12'd1 : ta;
  assign pa      = (i_r < size) ? i_r : lastidx;

  always_comb begin
    if (pass) begin
      tu.tap = {pa, pa, pa, pa};
      tu.frac = 16'd0;
    end else begin
      tu.tap[0] = (ta == 12'd0) ? 12'd0 : ta - 12'd1;
      tu.tap[1] = ta;
      tu.tap[2] = tb;
      tu.tap[3] = (tb < lastidx) ? tb + 12'd1 : tb;
      tu.frac = (ta == tb) ? 16'd0 : posc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_y || cmd.mul_x) begin
      prod_r <= 41'({(cmd.mul_x ? 12'(out_col) : out_row), 1'b1}) *
                41'(cmd.mul_x ? cfg.step_x : cfg.step_y);
      i_r    <= cmd.mul_x ? 12'(out_col) : out_row;
      sel_x  <= cmd.mul_x;
    end
    if (cmd.lat_y) begin
      ty_r <= tu;
    end
    if (cmd.lat_x) begin
      tx_r <= tu;
    end
    if (cmd.lat_slot) begin
      for (int r = 0; r < 4; r++) begin
        ysl[r] <= row_slot(ty_r.tap[r]);
      end
    end
    if (cmd.take_in) begin
      in_r <= in_data;
    end
  end

  // line ring
  assign we       = cmd.push && push_ok;
  assign waddr    = AW'(wslot) * AW'(MAX_WIDTH) + AW'(wcol);
  assign rd_issue = cmd.rd_run && !rd_cnt[4];
  assign raddr    = AW'(ysl[rd_cnt[3:2]]) * AW'(MAX_WIDTH) + AW'(tx_r.tap[rd_cnt[1:0]]);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {in_r.in_comp3, in_r.in_comp2, in_r.in_comp1, in_r.in_comp0};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      cap_en <= 1'b0;
    end else begin
      rd_cnt <= cmd.rd_run ? (rd_issue ? rd_cnt + 5'd1 : rd_cnt) : 5'd0;
      cap_en <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= rd_cnt[3:0];
    if (cap_en) begin
      tpx[cap_idx[3:2]][cap_idx[1:0]] <= rdata;
    end
  end

  // cubic feed
  assign feed = (cmd.run_h && (iss_cnt < 3'd4)) || (cmd.run_v && (iss_cnt == 3'd0));

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int l = 0; l < 4; l++) begin
        cub_taps[c][l] = cmd.run_v ? h[c][l] : tpx[iss_cnt[1:0]][c][8*l +: 8];
      end
    end
    cub_frac = cmd.run_v ? ty_r.frac : tx_r.frac;
  end

  bss_cubic u_cubic (
    .clk          (clk),
    .rst          (rst),
    .feed         (feed),
    .feed_tag     (iss_cnt[1:0]),
    .taps         (cub_taps),
    .frac         (cub_frac),
    .result_valid (cub_valid),
    .result_tag   (cub_tag),
    .result       (cub_res)
  );

  assign h_done = cmd.run_h && cub_valid && (cub_tag == 2'd3);
  assign v_done = cmd.run_v && cub_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt <= '0;
    end else if (!(cmd.run_h || cmd.run_v) || h_done) begin
      iss_cnt <= '0;
    end else if (feed) begin
      iss_cnt <= iss_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_h && cub_valid) begin
      h[cub_tag] <= cub_res;
    end
    if (v_done) begin
      pix <= cub_res;
    end
  end

  assign col_last = (32'(out_col) + 32'd1) >= 32'(ow);
  assign row_more = (13'(out_row) + 13'd1) < 13'(oh);

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_rcv <= '0;
      wcol     <= '0;
      wslot    <= '0;
      oldest   <= '0;
      out_row  <= '0;
      out_col  <= '0;
    end else begin
      if (we) begin
        if ((32'(wcol) + 32'd1) >= 32'(iw)) begin
          wcol     <= '0;
          rows_rcv <= rows_rcv + 12'd1;
          wslot    <= (wslot == SW'(LINE_ROWS - 1)) ? '0 : wslot + 1'b1;
        end else begin
          wcol <= wcol + 1'b1;
        end
      end
      if (cmd.advance) begin
        if (col_last) begin
          out_col <= '0;
          out_row <= out_row + 12'd1;
          if (!row_more) begin
            oldest <= ih;
          end
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (cmd.upd_oldest && (tu.tap[0] > oldest)) begin
        oldest <= tu.tap[0];
      end
    end
  end

  // result and output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res <= '{accepted: push_ok, default: '0};
    end else if (cmd.res_clear) begin
      res <= '0;
    end else if (cmd.advance) begin
      res.accepted    <= 1'b0;
      res.pixel_valid <= 1'b1;
      res.out_comp0   <= pix[0];
      res.out_comp1   <= (nc > 3'd1) ? pix[1] : 8'd0;
      res.out_comp2   <= (nc > 3'd2) ? pix[2] : 8'd0;
      res.out_comp3   <= (nc > 3'd3) ? pix[3] : 8'd0;
      res.row_end     <= col_last;
      res.frame_end   <= col_last && !row_more;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.pull_ok  = (out_row < oh) && (ty_r.tap[3] < rows_rcv);
  assign sts.rd_done  = cap_en && (cap_idx == 4'd15);
  assign sts.h_done   = h_done;
  assign sts.v_done   = v_done;
  assign sts.col_last = col_last;
  assign sts.row_more = row_more;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

[hw/rtl/bss_ctrl.sv]
// ----------------------------------------------------------------------------
// bss_ctrl
// Sequencer for push and pull words: taps, reads, cubic passes, advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl import bss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_cmd,
  output logic          in_stall,
  output bss_cmd_t      cmd,
  input  wire bss_sts_t sts
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_PUSH = 14'b00000000000010,
    S_TY1  = 14'b00000000000100,
    S_TY2  = 14'b00000000001000,
    S_CHK  = 14'b00000000010000,
    S_TX1  = 14'b00000000100000,
    S_TX2  = 14'b00000001000000,
    S_RD   = 14'b00000010000000,
    S_H    = 14'b00000100000000,
    S_V    = 14'b00001000000000,
    S_ADV  = 14'b00010000000000,
    S_NY1  = 14'b00100000000000,
    S_NY2  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next = (in_cmd == CMD_PULL) ? S_TY1 : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_next = S_OUT;
      end
      S_TY1: begin
        cmd.mul_y = 1'b1;
        state_next = S_TY2;
      end
      S_TY2: begin
        cmd.lat_y = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.pull_ok) begin
          state_next = S_TX1;
        end else begin
          cmd.res_clear = 1'b1;
          state_next = S_OUT;
        end
      end
      S_TX1: begin
        cmd.mul_x = 1'b1;
        cmd.lat_slot = 1'b1;
        state_next = S_TX2;
      end
      S_TX2: begin
        cmd.lat_x = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_run = 1'b1;
        if (sts.rd_done) begin
          state_next = S_H;
        end
      end
      S_H: begin
        cmd.run_h = 1'b1;
        if (sts.h_done) begin
          state_next = S_V;
        end
      end
      S_V: begin
        cmd.run_v = 1'b1;
        if (sts.v_done) begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = (sts.col_last && sts.row_more) ? S_NY1 : S_OUT;
      end
      S_NY1: begin
        cmd.mul_y = 1'b1;
        state_next = S_NY2;
      end
      S_NY2: begin
        cmd.upd_oldest = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bicubic_scanline_scaler.sv]
// ----------------------------------------------------------------------------
// bicubic_scanline_scaler
// Catmull-Rom scaler over a ring of source lines, with an APB register file.
// ----------------------------------------------------------------------------
// accept to out_valid: push via S_PUSH, pull via tap, read, cubic and advance
//   states (and S_NY1, S_NY2 at a row end), unserved pull via S_CHK, all to S_OUT;
//   one word in flight, next word taken back in S_IDLE; pull time is set by 16
//   reads of the single read port of the line ring and five passes through the
//   five-stage cubic pipe, out_stall holds the result in S_OUT; rst is synchronous:
//   counters, state, out_valid, cfg take reset values; data regs, line ring kept
`timescale 1ns / 1ps
`default_nettype none

module bicubic_scanline_scaler import bss_pkg::*; #(
  parameter int MAX_WIDTH = BSS_MAX_WIDTH,
  parameter int LINE_ROWS = BSS_LINE_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t     cfg;
  bss_cmd_t cmd;
  bss_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width   <= 12'd1;
      cfg.in_height  <= 12'd1;
      cfg.out_width  <= 12'd1;
      cfg.out_height <= 12'd1;
      cfg.components <= 3'd4;
      cfg.step_x     <= 28'd65536;
      cfg.step_y     <= 28'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_IN_WIDTH:   cfg.in_width   <= pwdata[11:0];
        REG_IN_HEIGHT:  cfg.in_height  <= pwdata[11:0];
        REG_OUT_WIDTH:  cfg.out_width  <= pwdata[11:0];
        REG_OUT_HEIGHT: cfg.out_height <= pwdata[11:0];
        REG_COMPONENTS: cfg.components <= pwdata[2:0];
        REG_STEP_X:     cfg.step_x     <= pwdata[27:0];
        REG_STEP_Y:     cfg.step_y     <= pwdata[27:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IN_WIDTH:   prdata = 32'(cfg.in_width);
      REG_IN_HEIGHT:  prdata = 32'(cfg.in_height);
      REG_OUT_WIDTH:  prdata = 32'(cfg.out_width);
      REG_OUT_HEIGHT: prdata = 32'(cfg.out_height);
      REG_COMPONENTS: prdata = 32'(cfg.components);
      REG_STEP_X:     prdata = 32'(cfg.step_x);
      REG_STEP_Y:     prdata = 32'(cfg.step_y);
      default:        prdata = 32'd0;
    endcase
  end

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bss_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .LINE_ROWS (LINE_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
